// ===== design/tnp_pkg.sv =====
// tnp_pkg: shared types, constants and fixed point helpers for the torus projection block
// used by tnp_alu and torus_newton_projection_top; no dependencies
`default_nettype none

package tnp_pkg;

    localparam int unsigned W            = 48;
    localparam int unsigned MAX_STEPS_DEF = 20;
    localparam logic [47:0] Q_MAX        = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] Q_MIN        = 48'h8000_0000_0000;
    localparam logic [47:0] TOL_RAW      = 48'd430;
    localparam logic signed [47:0] STEP_RAW = 48'sd42949673;
    localparam logic [95:0] RND_HALF     = 96'h8000_0000;
    localparam logic [47:0] ONE_Q        = 48'h0001_0000_0000;
    localparam logic [46:0] RING_RST     = 47'h0001_0000_0000;
    localparam logic [46:0] TUBE_RST     = 47'h0000_8000_0000;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RING_R   = 3'd3,
        REG_TUBE_R   = 3'd4
    } tnp_reg_t;

    // operations of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_DIV = 2'd1,
        OP_RAD = 2'd2
    } tnp_op_t;

    typedef enum logic [2:0] {
        AL_IDLE,
        AL_MUL,
        AL_DIV,
        AL_SQRT,
        AL_FIN
    } tnp_alu_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NX1, S_NX2, S_NY1, S_NY2, S_NZ1, S_NZ2,
        S_R2,
        S_PX, S_PY, S_PZ,
        S_RAD,
        S_EE, S_ZZ,
        S_CHK,
        S_N1, S_N2,
        S_DD,
        S_D1, S_D2,
        S_DT,
        S_OUT
    } tnp_state_t;

    typedef struct packed {
        logic               start;
        tnp_op_t            op;
        logic signed [47:0] a;
        logic signed [47:0] b;
    } tnp_alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [47:0] res;
    } tnp_alu_rsp_t;

    // sign extend to 50 bits
    function automatic logic signed [49:0] ext50(input logic signed [47:0] v);
        return {{2{v[47]}}, v};
    endfunction

    // saturate a 50 bit signed value to Q16.32
    function automatic logic signed [47:0] sat50(input logic signed [49:0] v);
        logic signed [47:0] r;
        begin
            if (v > ext50(Q_MAX))
                r = Q_MAX;
            else if (v < ext50(Q_MIN))
                r = Q_MIN;
            else
                r = v[47:0];
            return r;
        end
    endfunction

    // magnitude of a signed value, most negative gives 2^47
    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : v;
    endfunction

    // apply sign to a magnitude and saturate
    function automatic logic signed [47:0] smag(input logic [63:0] m, input logic neg);
        logic [47:0] mm;
        logic signed [47:0] r;
        begin
            mm = (m > {16'b0, Q_MIN}) ? Q_MIN : m[47:0];
            if (neg)
                r = 48'(-mm);
            else if (mm == Q_MIN)
                r = Q_MAX;
            else
                r = mm;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/tnp_alu.sv =====
// tnp_alu: shared iterative unit for rounded multiply, divide and radial square root
// depends on tnp_pkg
`default_nettype none

module tnp_alu
    import tnp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire tnp_alu_req_t req,
    output tnp_alu_rsp_t      rsp
);

    tnp_alu_state_t state_reg, state_next;
    tnp_op_t        op_reg;
    logic [6:0]     cnt_reg;
    logic [47:0]    ma_reg, mb_reg, yb_reg, root_reg;
    logic           neg_reg, second_reg;
    logic [95:0]    acc_reg;
    logic [49:0]    rem_reg;

    // partial product of the 24 bit halves
    logic [23:0] pa, pb;
    logic [47:0] pp;
    logic [95:0] pp_sh;
    // divide step
    logic [48:0] d_r2;
    logic        d_ge;
    // square root step
    logic [51:0] s_r2, s_trial;
    logic        s_ge;
    // finishing
    logic        over, rnd;
    logic [48:0] qq;
    logic signed [47:0] fin_res;

    always_comb
    begin
        pa = cnt_reg[0] ? ma_reg[47:24] : ma_reg[23:0];
        pb = cnt_reg[1] ? mb_reg[47:24] : mb_reg[23:0];
        pp = pa * pb;
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {48'b0, pp};
            2'd3:    pp_sh = {pp, 48'b0};
            default: pp_sh = {24'b0, pp, 24'b0};
        endcase
        d_r2    = {rem_reg[47:0], acc_reg[79]};
        d_ge    = d_r2 >= {1'b0, mb_reg};
        s_r2    = {rem_reg, acc_reg[95:94]};
        s_trial = {2'b0, root_reg, 2'b01};
        s_ge    = s_r2 >= s_trial;
        over    = |acc_reg[79:48];
        rnd     = !over && ({rem_reg[47:0], 1'b0} >= {1'b0, mb_reg});
        qq      = {1'b0, acc_reg[47:0]} + {48'b0, rnd};
        case (op_reg)
            OP_MUL:  fin_res = smag(acc_reg[95:32], neg_reg);
            OP_DIV:  fin_res = smag(over ? {16'b0, Q_MIN} : {15'b0, qq}, neg_reg);
            default: fin_res = smag({16'b0, root_reg}, 1'b0);
        endcase
    end

    // sequencer of the unit
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AL_IDLE:
                if (req.start)
                    state_next = (req.op == OP_DIV) ? AL_DIV : AL_MUL;
            AL_MUL:
                if (cnt_reg[1:0] == 2'd3)
                begin
                    if (op_reg == OP_MUL)
                        state_next = AL_FIN;
                    else if (second_reg)
                        state_next = AL_SQRT;
                end
            AL_DIV:
                if (cnt_reg == 7'd79)
                    state_next = AL_FIN;
            AL_SQRT:
                if (cnt_reg == 7'd47)
                    state_next = AL_FIN;
            AL_FIN:
                state_next = AL_IDLE;
            default:
                state_next = AL_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= AL_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            AL_IDLE:
                if (req.start)
                begin
                    op_reg     <= req.op;
                    cnt_reg    <= '0;
                    neg_reg    <= req.a[47] ^ req.b[47];
                    second_reg <= 1'b0;
                    rem_reg    <= '0;
                    root_reg   <= '0;
                    ma_reg     <= mag48(req.a);
                    yb_reg     <= mag48(req.b);
                    case (req.op)
                        OP_MUL:
                        begin
                            mb_reg  <= mag48(req.b);
                            acc_reg <= RND_HALF;
                        end
                        OP_DIV:
                        begin
                            mb_reg  <= mag48(req.b);
                            acc_reg <= {16'b0, mag48(req.a), 32'b0};
                        end
                        default:
                        begin
                            mb_reg  <= mag48(req.a);
                            acc_reg <= '0;
                        end
                    endcase
                end
            AL_MUL:
            begin
                acc_reg <= acc_reg + pp_sh;
                cnt_reg <= cnt_reg + 7'd1;
                // radial: second square follows the first
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_reg    <= '0;
                    second_reg <= 1'b1;
                    ma_reg     <= yb_reg;
                    mb_reg     <= yb_reg;
                end
            end
            AL_DIV:
            begin
                rem_reg <= {2'b0, d_ge ? 48'(d_r2 - {1'b0, mb_reg}) : d_r2[47:0]};
                acc_reg <= {16'b0, acc_reg[78:0], d_ge};
                cnt_reg <= cnt_reg + 7'd1;
            end
            AL_SQRT:
            begin
                rem_reg  <= s_ge ? 50'(s_r2 - s_trial) : s_r2[49:0];
                root_reg <= {root_reg[46:0], s_ge};
                acc_reg  <= {acc_reg[93:0], 2'b00};
                cnt_reg  <= cnt_reg + 7'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done = (state_reg == AL_FIN);
    assign rsp.res  = fin_res;

endmodule

`default_nettype wire

// ===== design/torus_newton_projection_top.sv =====
// Each item takes k Newton steps, k from 0 to MAX_STEPS+1, between a setup and a last evaluation;
// a step runs two divides, a radial root, nine multiplies and a check on the shared unit.
// Throughput: one transaction at a time; s_tready is high only while idle, so a new item is
// taken only after the previous result has been accepted at the output.
// Reset: rst_n asynchronous active low; registers return to centre 0, ring 1.0, tube 0.5.
// torus_newton_projection_top: sequencer and Newton datapath; depends on tnp_pkg, tnp_alu
`default_nettype none

module torus_newton_projection_top
    import tnp_pkg::*;
#(
    parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration write port
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [47:0]  cfg_wdata,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // start_x, start_y, start_z, first_tangent_x/y/z, second_tangent_x/y/z
    input  wire logic [431:0] s_tdata,
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_x, result_y, result_z
    output logic [143:0]      m_tdata,
    // converged
    output logic              m_tuser
);

    localparam int unsigned NW = $clog2(MAX_STEPS + 2);

    tnp_state_t state_reg, state_next;
    logic       pend_reg;

    logic signed [47:0] cx_reg, cy_reg, cz_reg;
    logic [46:0]        r1_reg, r2_reg;

    logic signed [47:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [47:0] x0_reg, y0_reg, z0_reg, nx_reg, ny_reg, nz_reg;
    logic signed [47:0] t_reg, r2sq_reg, x_reg, y_reg, z_reg, disc_reg;
    logic signed [47:0] e_reg, f_reg, num_reg, dd_reg, df_reg, p1_reg;
    logic signed [47:0] rx_reg, ry_reg, rz_reg;
    logic               conv_reg;
    logic [NW-1:0]      n_reg;

    tnp_alu_req_t alu_req;
    tnp_alu_rsp_t alu_rsp;
    logic         alu_state;

    logic signed [47:0] res, f_new, df_new, dt_raw, dt_clamp, e_new;
    logic               f_ok;

    tnp_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign res = alu_rsp.res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
            r1_reg <= RING_RST;
            r2_reg <= TUBE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CENTER_X: cx_reg <= cfg_wdata;
                REG_CENTER_Y: cy_reg <= cfg_wdata;
                REG_CENTER_Z: cz_reg <= cfg_wdata;
                REG_RING_R:   r1_reg <= cfg_wdata[46:0];
                REG_TUBE_R:   r2_reg <= cfg_wdata[46:0];
                default:
                begin
                end
            endcase
        end
    end

    // operand selection for the shared unit
    always_comb
    begin
        alu_state = 1'b1;
        alu_req.op = OP_MUL;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            S_NX1: begin alu_req.a = ay_reg; alu_req.b = bz_reg; end
            S_NX2: begin alu_req.a = az_reg; alu_req.b = by_reg; end
            S_NY1: begin alu_req.a = az_reg; alu_req.b = bx_reg; end
            S_NY2: begin alu_req.a = ax_reg; alu_req.b = bz_reg; end
            S_NZ1: begin alu_req.a = ax_reg; alu_req.b = by_reg; end
            S_NZ2: begin alu_req.a = ay_reg; alu_req.b = bx_reg; end
            S_R2:  begin alu_req.a = {1'b0, r2_reg}; alu_req.b = {1'b0, r2_reg}; end
            S_PX:  begin alu_req.a = t_reg; alu_req.b = nx_reg; end
            S_PY:  begin alu_req.a = t_reg; alu_req.b = ny_reg; end
            S_PZ:  begin alu_req.a = t_reg; alu_req.b = nz_reg; end
            S_RAD:
            begin
                alu_req.op = OP_RAD;
                alu_req.a  = x_reg;
                alu_req.b  = y_reg;
            end
            S_EE:  begin alu_req.a = e_reg; alu_req.b = e_reg; end
            S_ZZ:  begin alu_req.a = z_reg; alu_req.b = z_reg; end
            S_N1:  begin alu_req.a = nx_reg; alu_req.b = x_reg; end
            S_N2:  begin alu_req.a = ny_reg; alu_req.b = y_reg; end
            S_DD:
            begin
                alu_req.op = OP_DIV;
                alu_req.a  = num_reg;
                alu_req.b  = disc_reg;
            end
            S_D1:  begin alu_req.a = e_reg; alu_req.b = dd_reg; end
            S_D2:  begin alu_req.a = z_reg; alu_req.b = nz_reg; end
            S_DT:
            begin
                alu_req.op = OP_DIV;
                alu_req.a  = f_reg;
                alu_req.b  = df_reg;
            end
            default: alu_state = 1'b0;
        endcase
        alu_req.start = alu_state && !pend_reg;
    end

    // newton arithmetic around the unit
    always_comb
    begin
        e_new    = sat50(ext50(res) - {3'b0, r1_reg});
        f_new    = sat50(ext50(sat50(ext50(p1_reg) + ext50(res))) - ext50(r2sq_reg));
        df_new   = sat50({p1_reg[47], p1_reg, 1'b0} + {res[47], res, 1'b0});
        dt_raw   = sat50(-ext50(res));
        if (dt_raw > STEP_RAW)
            dt_clamp = STEP_RAW;
        else if (dt_raw < -STEP_RAW)
            dt_clamp = -STEP_RAW;
        else
            dt_clamp = dt_raw;
        f_ok     = mag48(f_reg) < TOL_RAW;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_NX1;
            S_NX1:  if (alu_rsp.done) state_next = S_NX2;
            S_NX2:  if (alu_rsp.done) state_next = S_NY1;
            S_NY1:  if (alu_rsp.done) state_next = S_NY2;
            S_NY2:  if (alu_rsp.done) state_next = S_NZ1;
            S_NZ1:  if (alu_rsp.done) state_next = S_NZ2;
            S_NZ2:  if (alu_rsp.done) state_next = S_R2;
            S_R2:   if (alu_rsp.done) state_next = S_PX;
            S_PX:   if (alu_rsp.done) state_next = S_PY;
            S_PY:   if (alu_rsp.done) state_next = S_PZ;
            S_PZ:   if (alu_rsp.done) state_next = S_RAD;
            S_RAD:  if (alu_rsp.done) state_next = S_EE;
            S_EE:   if (alu_rsp.done) state_next = S_ZZ;
            S_ZZ:   if (alu_rsp.done) state_next = S_CHK;
            S_CHK:
                if (f_ok || (n_reg > NW'(MAX_STEPS)) || (disc_reg == '0))
                    state_next = S_OUT;
                else
                    state_next = S_N1;
            S_N1:   if (alu_rsp.done) state_next = S_N2;
            S_N2:   if (alu_rsp.done) state_next = S_DD;
            S_DD:   if (alu_rsp.done) state_next = S_D1;
            S_D1:   if (alu_rsp.done) state_next = S_D2;
            S_D2:
                if (alu_rsp.done)
                    state_next = (df_new == '0) ? S_OUT : S_DT;
            S_DT:   if (alu_rsp.done) state_next = S_PX;
            S_OUT:  if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (alu_req.start)
                pend_reg <= 1'b1;
            else if (alu_rsp.done)
                pend_reg <= 1'b0;
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                begin
                    x0_reg   <= sat50(ext50(s_tdata[47:0])   - ext50(cx_reg));
                    y0_reg   <= sat50(ext50(s_tdata[95:48])  - ext50(cy_reg));
                    z0_reg   <= sat50(ext50(s_tdata[143:96]) - ext50(cz_reg));
                    ax_reg   <= s_tdata[191:144];
                    ay_reg   <= s_tdata[239:192];
                    az_reg   <= s_tdata[287:240];
                    bx_reg   <= s_tdata[335:288];
                    by_reg   <= s_tdata[383:336];
                    bz_reg   <= s_tdata[431:384];
                    t_reg    <= '0;
                    n_reg    <= '0;
                    rx_reg   <= '0;
                    ry_reg   <= '0;
                    rz_reg   <= '0;
                    conv_reg <= 1'b0;
                end
            S_NX1, S_NY1, S_NZ1, S_EE, S_N1, S_D1:
                if (alu_rsp.done) p1_reg <= res;
            S_NX2: if (alu_rsp.done) nx_reg <= sat50(ext50(p1_reg) - ext50(res));
            S_NY2: if (alu_rsp.done) ny_reg <= sat50(ext50(p1_reg) - ext50(res));
            S_NZ2: if (alu_rsp.done) nz_reg <= sat50(ext50(p1_reg) - ext50(res));
            S_R2:  if (alu_rsp.done) r2sq_reg <= res;
            S_PX:  if (alu_rsp.done) x_reg <= sat50(ext50(x0_reg) + ext50(res));
            S_PY:  if (alu_rsp.done) y_reg <= sat50(ext50(y0_reg) + ext50(res));
            S_PZ:  if (alu_rsp.done) z_reg <= sat50(ext50(z0_reg) + ext50(res));
            S_RAD:
                if (alu_rsp.done)
                begin
                    disc_reg <= res;
                    e_reg    <= e_new;
                end
            S_ZZ:  if (alu_rsp.done) f_reg <= f_new;
            S_CHK:
                if (f_ok)
                begin
                    rx_reg   <= sat50(ext50(cx_reg) + ext50(x_reg));
                    ry_reg   <= sat50(ext50(cy_reg) + ext50(y_reg));
                    rz_reg   <= sat50(ext50(cz_reg) + ext50(z_reg));
                    conv_reg <= 1'b1;
                end
            S_N2:  if (alu_rsp.done) num_reg <= sat50(ext50(p1_reg) + ext50(res));
            S_DD:  if (alu_rsp.done) dd_reg <= res;
            S_D2:  if (alu_rsp.done) df_reg <= df_new;
            S_DT:
                if (alu_rsp.done)
                begin
                    t_reg <= sat50(ext50(t_reg) + ext50(dt_clamp));
                    n_reg <= n_reg + NW'(1);
                end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {rz_reg, ry_reg, rx_reg};
    assign m_tuser  = conv_reg;

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("ready for input while a result is pending");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");
    a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> pend_reg)
        else $error("unit finished without a request");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failure result carries nonzero coordinates");
`endif

endmodule

`default_nettype wire

// ===== sim/torus_newton_projection_top_test.sv =====
// torus_newton_projection_top_test: self-checking bench for the torus projection block
// predicts each result in fixed point, checks the output stream; depends on tnp_pkg
`default_nettype none

module torus_newton_projection_top_test
    import tnp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSTEPS = 20;
    localparam int IDLE_LIMIT = 200000;
    localparam logic signed [47:0] SMAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SMIN = -48'sh8000_0000_0000;

    typedef struct packed {
        logic               conv;
        logic signed [47:0] rz;
        logic signed [47:0] ry;
        logic signed [47:0] rx;
    } proj_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [47:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [431:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tuser;

    torus_newton_projection_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // predictor copy of the registers
    logic signed [47:0] ctr_x, ctr_y, ctr_z;
    logic [46:0]        ring_r, tube_r;

    logic [431:0] pending_pts[$];
    proj_t        expected_proj[$];
    int           errors;
    int           idle_cycles;
    int           src_idle_pct;
    int           snk_idle_pct;
    int           hold_off;
    bit           stim_done;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // fixed point helpers
    function automatic logic signed [47:0] sat(input logic signed [63:0] v);
        if (v > 64'(SMAX))
            return SMAX;
        if (v < 64'(SMIN))
            return SMIN;
        return v[47:0];
    endfunction

    function automatic logic signed [47:0] apply_sign(input logic [127:0] m, input bit neg);
        logic [127:0] mm;
        mm = m;
        if (mm > 128'h8000_0000_0000)
            mm = 128'h8000_0000_0000;
        if (neg)
            return sat(-$signed({1'b0, mm[62:0]}));
        return sat($signed({1'b0, mm[62:0]}));
    endfunction

    function automatic logic [47:0] absval(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : v;
    endfunction

    function automatic logic signed [47:0] qmul(input logic signed [47:0] a,
                                                input logic signed [47:0] b);
        logic [127:0] p;
        bit neg;
        neg = a[47] != b[47];
        p = 128'(absval(a)) * 128'(absval(b)) + 128'h8000_0000;
        return apply_sign(p >> 32, neg);
    endfunction

    function automatic logic signed [47:0] qdiv(input logic signed [47:0] a,
                                                input logic signed [47:0] b);
        logic [127:0] num, den, q, r;
        bit neg;
        neg = a[47] != b[47];
        num = 128'(absval(a)) << 32;
        den = 128'(absval(b));
        q = num / den;
        r = num % den;
        if (q >= 128'h1_0000_0000_0000)
            q = 128'h8000_0000_0000;
        else if (2 * r >= den)
            q = q + 1;
        return apply_sign(q, neg);
    endfunction

    function automatic logic signed [47:0] radial_dist(input logic signed [47:0] x,
                                                       input logic signed [47:0] y);
        logic [127:0] s, c;
        logic [47:0] res;
        s = 128'(absval(x)) * 128'(absval(x)) + 128'(absval(y)) * 128'(absval(y));
        res = 0;
        for (int b = 47; b >= 0; b--)
        begin
            c = 128'(res | (48'd1 << b));
            if (c * c <= s)
                res = c[47:0];
        end
        if (res[47])
            res = 48'h7FFF_FFFF_FFFF;
        return res;
    endfunction

    function automatic logic signed [63:0] w(input logic signed [47:0] v);
        return 64'(v);
    endfunction

    // newton projection onto the configured torus
    function automatic proj_t project_point(input logic [431:0] d);
        logic signed [47:0] sx, sy, sz, ax, ay, az, bx, by, bz;
        logic signed [47:0] nx, ny, nz, x0, y0, z0, r1, r2sq, t;
        logic signed [47:0] x, y, z, disc, e, f, num, dd, df, dt;
        proj_t p;
        {bz, by, bx, az, ay, ax, sz, sy, sx} = d;
        p = '0;
        nx = sat(w(qmul(ay, bz)) - w(qmul(az, by)));
        ny = sat(w(qmul(az, bx)) - w(qmul(ax, bz)));
        nz = sat(w(qmul(ax, by)) - w(qmul(ay, bx)));
        x0 = sat(w(sx) - w(ctr_x));
        y0 = sat(w(sy) - w(ctr_y));
        z0 = sat(w(sz) - w(ctr_z));
        r1 = {1'b0, ring_r};
        r2sq = qmul({1'b0, tube_r}, {1'b0, tube_r});
        t = 0;
        for (int n = 0; n <= NSTEPS + 1; n++)
        begin
            x = sat(w(x0) + w(qmul(t, nx)));
            y = sat(w(y0) + w(qmul(t, ny)));
            z = sat(w(z0) + w(qmul(t, nz)));
            disc = radial_dist(x, y);
            e = sat(w(disc) - w(r1));
            f = sat(w(sat(w(qmul(e, e)) + w(qmul(z, z)))) - w(r2sq));
            if (absval(f) < 48'd430)
            begin
                p.rx = sat(w(ctr_x) + w(x));
                p.ry = sat(w(ctr_y) + w(y));
                p.rz = sat(w(ctr_z) + w(z));
                p.conv = 1'b1;
                return p;
            end
            if (n > NSTEPS || disc == 0)
                return p;
            num = sat(w(qmul(nx, x)) + w(qmul(ny, y)));
            dd = qdiv(num, disc);
            df = sat(2 * w(qmul(e, dd)) + 2 * w(qmul(z, nz)));
            if (df == 0)
                return p;
            dt = sat(-w(qdiv(f, df)));
            if (dt > STEP_RAW)
                dt = STEP_RAW;
            if (dt < -STEP_RAW)
                dt = -STEP_RAW;
            t = sat(w(t) + w(dt));
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // driver: offers queued points, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_proj.push_back(project_point(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_pts.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pts.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: compares each result transaction with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        proj_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_proj.size() == 0)
                    report_mismatch("unexpected transaction", m_tdata[47:0], 48'h0);
                else
                begin
                    want = expected_proj.pop_front();
                    if (m_tdata[47:0] !== want.rx)
                        report_mismatch("result_x", m_tdata[47:0], want.rx);
                    if (m_tdata[95:48] !== want.ry)
                        report_mismatch("result_y", m_tdata[95:48], want.ry);
                    if (m_tdata[143:96] !== want.rz)
                        report_mismatch("result_z", m_tdata[143:96], want.rz);
                    if (m_tuser !== want.conv)
                        report_mismatch("converged", 48'(m_tuser), 48'(want.conv));
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input tnp_reg_t idx, input logic [47:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CENTER_X: ctr_x = val;
            REG_CENTER_Y: ctr_y = val;
            REG_CENTER_Z: ctr_z = val;
            REG_RING_R:   ring_r = val[46:0];
            REG_TUBE_R:   tube_r = val[46:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_results;
        while (pending_pts.size() > 0 || s_tvalid || expected_proj.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [47:0] rnd48();
        return {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
    endfunction

    // small Q16.32 value in about +-range units
    function automatic logic [47:0] rnd_near(input int range);
        return 48'($signed(64'($urandom_range(2 * range * 65536)) - 64'(range * 65536)) <<< 16);
    endfunction

    function automatic logic [431:0] pack_pt(input logic [47:0] f[9]);
        logic [431:0] d;
        for (int i = 0; i < 9; i++)
            d[i*48 +: 48] = f[i];
        return d;
    endfunction

    // near-torus point; in half the cases the tangents lie along the y and z axes, else they are random
    function automatic logic [431:0] good_point();
        logic [47:0] f[9];
        for (int i = 0; i < 9; i++)
            f[i] = rnd_near(1);
        f[0] = 48'($signed(ctr_x) + $signed({1'b0, ring_r}) + $signed(rnd_near(1)));
        f[1] = 48'($signed(ctr_y) + $signed(rnd_near(1)));
        f[2] = 48'($signed(ctr_z) + $signed(rnd_near(1)));
        if ($urandom_range(1))
        begin
            f[3] = 48'h0;
            f[4] = 48'h1_0000_0000;
            f[5] = 48'h0;
            f[6] = 48'h0;
            f[7] = 48'h0;
            f[8] = 48'h1_0000_0000;
        end
        return pack_pt(f);
    endfunction

    function automatic logic [431:0] noise_point();
        logic [47:0] f[9];
        for (int i = 0; i < 9; i++)
            f[i] = $urandom_range(1) ? rnd48() : rnd_near(4);
        return pack_pt(f);
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            pending_pts.push_back($urandom_range(99) < 80 ? good_point() : noise_point());
    endtask

    initial
    begin
        logic [47:0] f[9];
        errors = 0;
        stim_done = 0;
        hold_off = 0;
        src_idle_pct = 16;
        snk_idle_pct = 74;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        ctr_x = 0;
        ctr_y = 0;
        ctr_z = 0;
        ring_r = RING_RST;
        tube_r = TUBE_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, on torus, zero normal, radial zero, extremes
        f = '{48'h1_8000_0000, 0, 0, 0, 48'h1_0000_0000, 0, 0, 0, 48'h1_0000_0000};
        pending_pts.push_back(pack_pt(f));
        f = '{48'h1_4000_0000, 0, 48'h1000_0000, 0, 48'h1_0000_0000, 0, 0, 0,
              48'h1_0000_0000};
        pending_pts.push_back(pack_pt(f));
        f = '{48'h1_4000_0000, 0, 0, 0, 0, 0, 0, 0, 0};
        pending_pts.push_back(pack_pt(f));
        f = '{0, 0, 0, 48'h1_0000_0000, 0, 0, 0, 48'h1_0000_0000, 0};
        pending_pts.push_back(pack_pt(f));
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 9; i++)
                f[i] = (k == 0) ? 48'h7FFF_FFFF_FFFF : (k == 1) ? 48'h8000_0000_0000 :
                       (k == 2) ? 48'hFFFF_FFFF_FFFF : ((i % 2) ? 48'h8000_0000_0000 :
                                                       48'h7FFF_FFFF_FFFF);
            pending_pts.push_back(pack_pt(f));
        end
        for (int i = 0; i < 12; i++)
            pending_pts.push_back(good_point());
        drain_results();

        // long receiver hold-off while points keep arriving
        hold_off = 3000;
        run_random(120);
        drain_results();

        // new centre and radii, swapped idling
        src_idle_pct = 74;
        snk_idle_pct = 16;
        write_reg(REG_CENTER_X, rnd_near(8));
        write_reg(REG_CENTER_Y, rnd_near(8));
        write_reg(REG_CENTER_Z, rnd_near(8));
        write_reg(REG_RING_R, 48'h2_0000_0000);
        write_reg(REG_TUBE_R, 48'h0_C000_0000);
        run_random(130);
        drain_results();

        // extreme settings: zero tube and ring with a corner centre, then largest ring and tube
        write_reg(REG_TUBE_R, 48'h0);
        write_reg(REG_RING_R, 48'h0);
        write_reg(REG_CENTER_X, 48'h8000_0000_0000);
        write_reg(REG_CENTER_Y, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_CENTER_Z, 48'h0);
        run_random(40);
        drain_results();
        write_reg(REG_RING_R, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_TUBE_R, 48'h7FFF_FFFF_FFFF);
        write_reg(REG_CENTER_X, 48'h0);
        write_reg(REG_CENTER_Y, 48'h0);
        run_random(40);
        drain_results();

        // back to a modest torus, no idling
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(REG_RING_R, 48'h1_8000_0000);
        write_reg(REG_TUBE_R, 48'h0_4000_0000);
        write_reg(REG_CENTER_Z, 48'hFFFF_0000_0000);
        run_random(150);
        drain_results();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
